@@ src/ablr_pkg.sv @@
// Package for the alpha blend line/rect raster engine.
// Holds defaults, command codes, state encoding and the blend function.
// No dependencies.
package ablr_pkg;

  localparam int unsigned FbWidthDef  = 256;
  localparam int unsigned FbHeightDef = 256;
  localparam int unsigned PixelW      = 32;  // RGBA8, four bytes per pixel
  localparam int unsigned CoordW      = 12;  // signed working coordinate

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PIX,
    ST_WR,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  // floor((old*(255-a) + c*a) / 255), exact for 16-bit sums
  function automatic logic [7:0] blend_ch(input logic [7:0] oldc, input logic [7:0] c,
                                          input logic [7:0] a);
    logic [15:0] sum;
    logic [16:0] tmp;
    sum = 16'(oldc) * 16'(8'd255 - a) + 16'(c) * 16'(a);
    tmp = 17'(sum) + 17'(sum[15:8]) + 17'd1;
    return tmp[15:8];
  endfunction

endpackage

@@ src/ablr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ablr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/alpha_blend_line_rect_raster.sv @@
// Small 2D drawing engine over an RGBA8 framebuffer of FB_WIDTH x FB_HEIGHT words held in one
// RAM (red 7:0, green 15:8, blue 23:16, alpha 31:24). Commands: clear (every pixel set to the
// colour, no blend), fill rectangle, DDA line (end point excluded) and read pixel. Drawing
// blends each channel as floor((old*(255-a)+c*a)/255) and stores a as alpha; off-screen pixels
// are skipped. Every command returns one result word; only a read returns nonzero data.
// Each command is handled one at a time. A visible pixel takes a RAM read, then a blend and
// write back; a clipped one is only stepped past; clear writes one word per cycle over the
// whole store; a read takes a RAM read and a capture (no capture when off-screen); every
// command also passes an accept and a finish step. After reset a zeroing sweep over all
// FB_WIDTH*FB_HEIGHT words runs while in_ready_o stays low. The result sits in an output
// register; a new command may run while it waits, and only its finish stalls.
// Depends on ablr_pkg and ablr_ram.
module alpha_blend_line_rect_raster #(
  parameter int unsigned FB_WIDTH  = ablr_pkg::FbWidthDef,
  parameter int unsigned FB_HEIGHT = ablr_pkg::FbHeightDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic signed [9:0]    x_first_i,
  input  logic signed [9:0]    y_first_i,
  input  logic signed [9:0]    x_second_i,
  input  logic signed [9:0]    y_second_i,
  input  logic [8:0]           rect_width_i,
  input  logic [8:0]           rect_height_i,
  input  logic [7:0]           red_i,
  input  logic [7:0]           green_i,
  input  logic [7:0]           blue_i,
  input  logic [7:0]           alpha_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           pixel_red_o,
  output logic [7:0]           pixel_green_o,
  output logic [7:0]           pixel_blue_o,
  output logic [7:0]           pixel_alpha_o,
  output logic                 in_range_o
);
  import ablr_pkg::*;

  localparam int unsigned Depth = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
  localparam logic [AW-1:0] RowLen   = AW'(FB_WIDTH);

  typedef logic signed [CoordW-1:0] crd_t;

  state_e state_q, state_d;

  // command context
  cmd_e              cmd_q, cmd_d;
  logic [PixelW-1:0] col_q, col_d;
  crd_t              px_q, px_d, py_q, py_d, y0_q, y0_d;
  logic [8:0]        ci_q, ci_d, cj_q, cj_d, rw_q, rw_d, rh_q, rh_d;
  // line stepper: n counts steps, rem is the running remainder of dmin*n/len
  logic [9:0]        n_q, n_d, len_q, len_d;
  logic signed [10:0] dmin_q, dmin_d;
  logic signed [12:0] rem_q, rem_d;
  logic              majx_q, majx_d, neg_q, neg_d;
  logic [AW-1:0]     addr_q, addr_d, clr_q, clr_d;
  logic [PixelW-1:0] res_q, res_d;
  logic              res_in_q, res_in_d;
  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] out_q, out_d;
  logic              out_in_q, out_in_d;

  logic              in_fire, out_free;
  logic              pix_in, last, load_out;
  logic [AW-1:0]     pix_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [PixelW-1:0] wdata, rdata;

  // stepping results
  crd_t              adv_px, adv_py;
  logic [8:0]        adv_ci, adv_cj;
  logic [9:0]        adv_n;
  logic signed [12:0] adv_rem;

  // accept-time line setup
  logic signed [10:0] dx, dy, adx, ady;
  crd_t               xf, yf;

  ablr_ram #(.Width(PixelW), .Depth(Depth)) u_fb (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (pix_addr),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_DONE) && out_free;

  assign xf = crd_t'(x_first_i);
  assign yf = crd_t'(y_first_i);
  assign dx = 11'(x_second_i) - 11'(x_first_i);
  assign dy = 11'(y_second_i) - 11'(y_first_i);
  assign adx = dx[10] ? -dx : dx;
  assign ady = dy[10] ? -dy : dy;

  // clip test and word address of the current pixel
  assign pix_in = !px_q[CoordW-1] && (px_q[CoordW-2:0] < (CoordW-1)'(FB_WIDTH)) &&
                  !py_q[CoordW-1] && (py_q[CoordW-2:0] < (CoordW-1)'(FB_HEIGHT));
  assign pix_addr = AW'(AW'(py_q[CoordW-2:0]) * RowLen) + AW'(px_q[CoordW-2:0]);

  // next pixel of a rectangle (column-major: down each column, then the next) or a line
  always_comb begin
    logic signed [12:0] rs;
    logic signed [12:0] dmaj;
    rs      = rem_q + 13'(dmin_q);
    dmaj    = 13'(len_q);
    adv_px  = px_q;
    adv_py  = py_q;
    adv_ci  = ci_q;
    adv_cj  = cj_q;
    adv_n   = n_q + 10'd1;
    adv_rem = rs;
    if (cmd_q == CMD_RECT) begin
      last = (ci_q == rw_q - 9'd1) && (cj_q == rh_q - 9'd1);
      if (cj_q == rh_q - 9'd1) begin
        adv_cj = '0;
        adv_py = y0_q;
        adv_ci = ci_q + 9'd1;
        adv_px = px_q + crd_t'(1);
      end else begin
        adv_cj = cj_q + 9'd1;
        adv_py = py_q + crd_t'(1);
      end
    end else begin
      last = (n_q == len_q - 10'd1);
      if (majx_q) begin
        adv_px = neg_q ? px_q - crd_t'(1) : px_q + crd_t'(1);
      end else begin
        adv_py = neg_q ? py_q - crd_t'(1) : py_q + crd_t'(1);
      end
      if (rs >= dmaj) begin
        adv_rem = rs - dmaj;
        if (majx_q) adv_py = py_q + crd_t'(1);
        else        adv_px = px_q + crd_t'(1);
      end else if (rs < 0) begin
        adv_rem = rs + dmaj;
        if (majx_q) adv_py = py_q - crd_t'(1);
        else        adv_px = px_q - crd_t'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (clr_q == LastAddr) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(command_i))
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_RECT:  state_d = (rect_width_i == '0 || rect_height_i == '0) ? ST_DONE : ST_PIX;
            CMD_LINE:  state_d = (dx == '0 && dy == '0) ? ST_DONE : ST_PIX;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR:     if (clr_q == LastAddr) state_d = ST_DONE;
      ST_PIX:       state_d = pix_in ? ST_WR : (last ? ST_DONE : ST_PIX);
      ST_WR:        state_d = last ? ST_DONE : ST_PIX;
      ST_READ:      state_d = pix_in ? ST_READ_WAIT : ST_DONE;
      ST_READ_WAIT: state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_INIT;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    cmd_d = cmd_q;   col_d = col_q;   px_d = px_q;     py_d = py_q;   y0_d = y0_q;
    ci_d = ci_q;     cj_d = cj_q;     rw_d = rw_q;     rh_d = rh_q;
    n_d = n_q;       len_d = len_q;   dmin_d = dmin_q; rem_d = rem_q;
    majx_d = majx_q; neg_d = neg_q;   addr_d = addr_q; clr_d = clr_q;
    res_d = res_q;   res_in_d = res_in_q;
    out_d = out_q;   out_in_d = out_in_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we    = 1'b0;
    waddr = addr_q;
    wdata = {col_q[31:24],
             blend_ch(rdata[23:16], col_q[23:16], col_q[31:24]),
             blend_ch(rdata[15:8],  col_q[15:8],  col_q[31:24]),
             blend_ch(rdata[7:0],   col_q[7:0],   col_q[31:24])};
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (state_q == ST_INIT) ? '0 : col_q;
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d    = cmd_e'(command_i);
          col_d    = {alpha_i, blue_i, green_i, red_i};
          px_d     = xf;
          py_d     = yf;
          y0_d     = yf;
          ci_d     = '0;
          cj_d     = '0;
          rw_d     = rect_width_i;
          rh_d     = rect_height_i;
          n_d      = '0;
          rem_d    = '0;
          majx_d   = adx > ady;
          neg_d    = (adx > ady) ? dx[10] : dy[10];
          len_d    = (adx > ady) ? adx[9:0] : ady[9:0];
          dmin_d   = (adx > ady) ? dy : dx;
          clr_d    = '0;
          res_d    = '0;
          res_in_d = 1'b0;
        end
      end
      ST_PIX: begin
        addr_d = pix_addr;
        if (!pix_in) begin
          px_d = adv_px; py_d = adv_py; ci_d = adv_ci; cj_d = adv_cj;
          n_d = adv_n;   rem_d = adv_rem;
        end
      end
      ST_WR: begin
        we   = 1'b1;
        px_d = adv_px; py_d = adv_py; ci_d = adv_ci; cj_d = adv_cj;
        n_d  = adv_n;  rem_d = adv_rem;
      end
      ST_READ_WAIT: begin
        res_d    = rdata;
        res_in_d = 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_in_d    = res_in_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;   col_q <= col_d;   px_q <= px_d;     py_q <= py_d;   y0_q <= y0_d;
    ci_q <= ci_d;     cj_q <= cj_d;     rw_q <= rw_d;     rh_q <= rh_d;
    n_q <= n_d;       len_q <= len_d;   dmin_q <= dmin_d; rem_q <= rem_d;
    majx_q <= majx_d; neg_q <= neg_d;   addr_q <= addr_d;
    res_q <= res_d;   res_in_q <= res_in_d;
    out_q <= out_d;   out_in_q <= out_in_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = out_q[7:0];
  assign pixel_green_o = out_q[15:8];
  assign pixel_blue_o  = out_q[23:16];
  assign pixel_alpha_o = out_q[31:24];
  assign in_range_o    = out_in_q;

endmodule

@@ src/ablr_chk.sv @@
// Port-level checker for the raster engine, bound to the top level.
// Depends on alpha_blend_line_rect_raster's port list.
module ablr_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] pixel_red_o,
  input logic [7:0] pixel_green_o,
  input logic [7:0] pixel_blue_o,
  input logic [7:0] pixel_alpha_o,
  input logic       in_range_o
);

  // a word held back is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result word dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_red_o) && $stable(pixel_green_o) &&
      $stable(pixel_blue_o) && $stable(pixel_alpha_o) && $stable(in_range_o))
    else $error("result word changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second command taken early");

  // off-screen or non-read results carry zero pixel data
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> pixel_red_o == '0 && pixel_green_o == '0 &&
      pixel_blue_o == '0 && pixel_alpha_o == '0) else $error("nonzero data out of range");

endmodule

bind alpha_blend_line_rect_raster ablr_chk u_ablr_chk (.*);

@@ dv/tb_top.sv @@
// Testbench for alpha_blend_line_rect_raster: a directed table, then ~2000 random commands.
// Results are checked against the table's word where given, else a framebuffer predictor.
// Depends on ablr_pkg and the RTL of the block.
module tb_top;
  import ablr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Width  = 256;
  localparam int unsigned Height = 256;
  localparam int          NumRandom = 2000;

  // One command word as driven on the input channel.
  typedef struct {
    cmd_e              cmd;
    logic signed [9:0] xf, yf, xs, ys;
    logic [8:0]        w, h;
    logic [7:0]        r, g, b, a;
  } draw_word_t;

  // One pixel word as returned on the output channel.
  typedef struct {
    logic [7:0] r, g, b, a;
    logic       in_range;
  } pixel_word_t;

  typedef struct {
    draw_word_t  word;
    bit          typed;  // expected pixel word given in the table
    pixel_word_t want;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] command_i;
  logic signed [9:0] x_first_i, y_first_i, x_second_i, y_second_i;
  logic [8:0] rect_width_i, rect_height_i;
  logic [7:0] red_i, green_i, blue_i, alpha_i;
  logic [7:0] pixel_red_o, pixel_green_o, pixel_blue_o, pixel_alpha_o;
  logic in_range_o;

  // Bench copy of the framebuffer: red 7:0, green 15:8, blue 23:16, alpha 31:24.
  logic [31:0] frame_copy [Width*Height];
  pixel_word_t pending_pixels [$];
  table_row_t  stim_table [$];

  int  n_errors   = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_reads    = 0;
  int  n_clears   = 0;
  bit  sender_fast = 1'b0;  // stretch with no sender gaps
  bit  hold_reader = 1'b0;  // asks the receiver for one long stall
  bit  stim_done   = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  alpha_blend_line_rect_raster dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .command_i, .x_first_i, .y_first_i, .x_second_i, .y_second_i,
    .rect_width_i, .rect_height_i,
    .red_i, .green_i, .blue_i, .alpha_i,
    .out_valid_o, .out_ready_i,
    .pixel_red_o, .pixel_green_o, .pixel_blue_o, .pixel_alpha_o,
    .in_range_o
  );

  // ---------------------------------------------------------------- predictor

  function automatic int floor_quot(int n, int d);
    int q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic [7:0] mix_channel(int oldc, int c, int a);
    int v;
    v = (oldc * (255 - a) + c * a) / 255;
    return v[7:0];
  endfunction

  // Blend one pixel into the copy; off-screen pixels are dropped.
  function automatic void blend_pixel(int x, int y, draw_word_t dw);
    logic [31:0] old;
    int idx;
    if (x < 0 || x >= Width || y < 0 || y >= Height) return;
    idx = y * Width + x;
    old = frame_copy[idx];
    frame_copy[idx] = {dw.a, mix_channel(old[23:16], dw.b, dw.a),
                       mix_channel(old[15:8], dw.g, dw.a), mix_channel(old[7:0], dw.r, dw.a)};
  endfunction

  // Applies one command to the copy and returns the pixel word it yields.
  function automatic pixel_word_t draw_and_read(draw_word_t dw);
    pixel_word_t res;
    int x1, y1, dx, dy, adx, ady, s, t;
    logic [31:0] pix;
    res = '{default: '0};
    x1 = dw.xf;
    y1 = dw.yf;
    case (dw.cmd)
      CMD_CLEAR: foreach (frame_copy[k]) frame_copy[k] = {dw.a, dw.b, dw.g, dw.r};
      CMD_RECT: begin
        for (int i = 0; i < int'(dw.w); i++)
          for (int j = 0; j < int'(dw.h); j++) blend_pixel(x1 + i, y1 + j, dw);
      end
      CMD_LINE: begin
        dx = int'(dw.xs) - x1;
        dy = int'(dw.ys) - y1;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        // x is the major axis only when strictly longer; equal ends draw nothing
        if (adx > ady) begin
          s = dx < 0 ? -1 : 1;
          for (int n = 0; n < adx; n++) begin
            t = n * s;
            blend_pixel(x1 + t, y1 + floor_quot(dy * t, dx), dw);
          end
        end else if (ady != 0) begin
          s = dy < 0 ? -1 : 1;
          for (int n = 0; n < ady; n++) begin
            t = n * s;
            blend_pixel(x1 + floor_quot(dx * t, dy), y1 + t, dw);
          end
        end
      end
      default: begin
        if (x1 >= 0 && x1 < Width && y1 >= 0 && y1 < Height) begin
          pix = frame_copy[y1 * Width + x1];
          res = '{pix[7:0], pix[15:8], pix[23:16], pix[31:24], 1'b1};
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(string field, int got, int want);
    n_errors++;
    $display("mismatch @%0t: %s got %0h want %0h", $realtime, field, got, want);
  endtask

  // ---------------------------------------------------------------- sender

  task automatic send_word(draw_word_t dw, bit typed, pixel_word_t want);
    int gap;
    pixel_word_t pred;
    gap = sender_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= dw.cmd;
    x_first_i     <= dw.xf;
    y_first_i     <= dw.yf;
    x_second_i    <= dw.xs;
    y_second_i    <= dw.ys;
    rect_width_i  <= dw.w;
    rect_height_i <= dw.h;
    red_i         <= dw.r;
    green_i       <= dw.g;
    blue_i        <= dw.b;
    alpha_i       <= dw.a;
    do @(posedge clk_i); while (!in_ready_o);
    pred = draw_and_read(dw);
    pending_pixels.push_back(typed ? want : pred);
    n_sent++;
    if (dw.cmd == CMD_READ) n_reads++;
    if (dw.cmd == CMD_CLEAR) n_clears++;
  endtask

  task automatic add_row(cmd_e cmd, int xf, int yf, int xs, int ys, int w, int h,
                         logic [31:0] rgba, bit typed, logic [31:0] want_rgba, bit want_in);
    table_row_t row;
    row.word  = '{cmd, 10'(xf), 10'(yf), 10'(xs), 10'(ys), 9'(w), 9'(h),
                  rgba[31:24], rgba[23:16], rgba[15:8], rgba[7:0]};
    row.typed = typed;
    row.want  = '{want_rgba[31:24], want_rgba[23:16], want_rgba[15:8], want_rgba[7:0],
                  want_in};
    stim_table.push_back(row);
  endtask

  // Mostly on or near the screen, now and then anywhere in the signed range.
  function automatic int pick_coord();
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 1023)) - 512;
    return int'($urandom_range(0, 300)) - 20;
  endfunction

  // Rect sizes stay small; a few run past 256 to exercise bit 8 and clipping.
  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 88) return $urandom_range(0, 12);
    if (sel < 98) return $urandom_range(0, 40);
    return $urandom_range(256, 511);
  endfunction

  function automatic draw_word_t random_word(int last_x, int last_y);
    draw_word_t dw;
    int sel;
    sel = $urandom_range(0, 999);
    dw.cmd = sel < 3 ? CMD_CLEAR : sel < 330 ? CMD_RECT : sel < 630 ? CMD_LINE : CMD_READ;
    dw.xf = 10'(pick_coord());
    dw.yf = 10'(pick_coord());
    dw.xs = 10'(pick_coord());
    dw.ys = 10'(pick_coord());
    // reads often land on the last drawn spot, so blends get seen
    if (dw.cmd == CMD_READ && $urandom_range(0, 1) == 0) begin
      dw.xf = 10'(last_x + int'($urandom_range(0, 4)) - 2);
      dw.yf = 10'(last_y + int'($urandom_range(0, 4)) - 2);
    end
    dw.w = 9'(pick_size());
    dw.h = 9'(pick_size());
    // a wide rect stays short, a tall one narrow
    if (dw.w > 40) dw.h = 9'($urandom_range(0, 3));
    else if (dw.h > 40) dw.w = 9'($urandom_range(0, 3));
    dw.r = 8'($urandom);
    dw.g = 8'($urandom);
    dw.b = 8'($urandom);
    sel = $urandom_range(0, 9);
    dw.a = sel < 2 ? 8'd0 : sel < 4 ? 8'd255 : 8'($urandom);
    return dw;
  endfunction

  initial begin
    draw_word_t dw;
    int last_x, last_y;
    in_valid_i    = 1'b0;
    command_i     = CMD_READ;
    x_first_i     = '0;
    y_first_i     = '0;
    x_second_i    = '0;
    y_second_i    = '0;
    rect_width_i  = '0;
    rect_height_i = '0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    alpha_i       = '0;
    foreach (frame_copy[k]) frame_copy[k] = '0;

    // after reset: store is zero, reads outside give in_range low
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 32'h0, 1);
    add_row(CMD_READ, 255, 255, 0, 0, 0, 0, 0, 1, 32'h0, 1);
    add_row(CMD_READ, -512, 0, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(CMD_READ, 256, 5, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(CMD_READ, 5, 511, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(CMD_READ, 0, -1, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    // clear writes the colour unblended
    add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h11223344, 1, 32'h0, 0);
    add_row(CMD_READ, 10, 10, 0, 0, 0, 0, 0, 1, 32'h11223344, 1);
    // opaque fill replaces, transparent fill keeps colour and stores alpha 0
    add_row(CMD_RECT, 0, 0, 0, 0, 4, 3, 32'hAABBCCFF, 1, 32'h0, 0);
    add_row(CMD_READ, 3, 2, 0, 0, 0, 0, 0, 1, 32'hAABBCCFF, 1);
    add_row(CMD_RECT, 0, 0, 0, 0, 1, 1, 32'hFFFFFF00, 1, 32'h0, 0);
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1, 32'hAABBCC00, 1);
    // zero width or height draws nothing
    add_row(CMD_RECT, 5, 5, 0, 0, 0, 9, 32'hFFFFFFFF, 1, 32'h0, 0);
    add_row(CMD_RECT, 5, 5, 0, 0, 9, 0, 32'hFFFFFFFF, 1, 32'h0, 0);
    add_row(CMD_READ, 5, 5, 0, 0, 0, 0, 0, 1, 32'h11223344, 1);
    // clipped rects, one wider than the screen
    add_row(CMD_RECT, -3, -3, 0, 0, 300, 4, 32'h8040207F, 0, 32'h0, 0);
    add_row(CMD_RECT, 250, 250, 0, 0, 10, 10, 32'h0F1E2D3C, 0, 32'h0, 0);
    add_row(CMD_READ, 255, 0, 0, 0, 0, 0, 0, 0, 32'h0, 0);
    // equal endpoints draw nothing
    add_row(CMD_LINE, 20, 20, 20, 20, 0, 0, 32'hFFFFFFFF, 1, 32'h0, 0);
    add_row(CMD_READ, 20, 20, 0, 0, 0, 0, 0, 1, 32'h11223344, 1);
    // both major axes, both directions, the diagonal, and the coordinate extremes
    add_row(CMD_LINE, 0, 0, 40, 7, 0, 0, 32'h10203080, 0, 32'h0, 0);
    add_row(CMD_LINE, 40, 100, 0, 90, 0, 0, 32'h90A0B0C0, 0, 32'h0, 0);
    add_row(CMD_LINE, 100, 0, 93, 50, 0, 0, 32'h55667788, 0, 32'h0, 0);
    add_row(CMD_LINE, 60, 60, 30, 30, 0, 0, 32'hFEDCBA99, 0, 32'h0, 0);
    add_row(CMD_LINE, -512, -512, 511, 511, 0, 0, 32'h123456FF, 0, 32'h0, 0);
    add_row(CMD_LINE, 511, -512, -512, 511, 0, 0, 32'h65432101, 0, 32'h0, 0);
    add_row(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 32'h0, 0);
    add_row(CMD_READ, 97, 25, 0, 0, 0, 0, 0, 0, 32'h0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the first word waits out the zeroing sweep through the handshake
    foreach (stim_table[i]) send_word(stim_table[i].word, stim_table[i].typed,
                                      stim_table[i].want);

    last_x = 0;
    last_y = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0) sender_fast = ($urandom_range(0, 3) == 0);
      if (i == 300) hold_reader = 1'b1;
      if (i == 1000) begin
        // drain everything before going on
        in_valid_i <= 1'b0;
        wait (pending_pixels.size() == 0);
        @(posedge clk_i);
      end
      dw = random_word(last_x, last_y);
      if (dw.cmd != CMD_READ) begin
        last_x = dw.xf;
        last_y = dw.yf;
      end
      send_word(dw, 1'b0, '{default: '0});
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int stall;
    bit fast;
    pixel_word_t want;
    out_ready_i = 1'b0;
    fast = 1'b0;
    forever begin
      if ($urandom_range(0, 40) == 0) fast = ~fast;
      stall = fast ? 0 : $urandom_range(0, 13);
      if (hold_reader) begin
        // long hold so the output register fills and the input stalls
        stall = 400;
        hold_reader = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if (pending_pixels.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (pixel_red_o   !== want.r) report("pixel_red", pixel_red_o, want.r);
        if (pixel_green_o !== want.g) report("pixel_green", pixel_green_o, want.g);
        if (pixel_blue_o  !== want.b) report("pixel_blue", pixel_blue_o, want.b);
        if (pixel_alpha_o !== want.a) report("pixel_alpha", pixel_alpha_o, want.a);
        if (in_range_o    !== want.in_range) report("in_range", in_range_o, want.in_range);
      end
    end
  end

  // ---------------------------------------------------------------- end of run

  initial begin
    wait (stim_done);
    wait (pending_pixels.size() == 0);
    // wait on to catch stray words
    repeat (50) @(posedge clk_i);
    $display("covered %0d commands (%0d reads, %0d clears), %0d result words checked",
             n_sent, n_reads, n_clears, n_checked);
    $display("%0d words still outstanding, %0d mismatches", pending_pixels.size(), n_errors);
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d words outstanding", pending_pixels.size());
    $display("status: fail");
    $finish;
  end

endmodule
